// ===== rtl/core/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Shared constants and the command bundle that passes from the controller to
// the datapath.
// ----------------------------------------------------------------------------
package skf_pkg;

    // configuration register width and index codes
    localparam int REG_W       = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;

    // gain is a fraction with 16 fraction bits, 1.0 needs one more bit
    localparam int GAIN_BITS = 16;
    localparam int GAIN_W    = GAIN_BITS + 1;
    localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {GAIN_BITS{1'b0}}};

    // divider takes one quotient bit per step
    localparam int DIV_STEPS = GAIN_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // datapath commands, at most one high in any cycle
    typedef struct packed {
        logic load_in;
        logic calc_prior;
        logic div_init;
        logic div_step;
        logic mul_gain;
        logic mul_cov;
        logic update_cov;
        logic load_out;
    } cmd_t;

endpackage

// ===== rtl/core/skf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter controller
// One-hot sequencer that walks one sample through prior, division,
// multiplies and result hand-off, and owns the handshake flags.
// ----------------------------------------------------------------------------
module skf_ctrl
    import skf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  logic div_done,
    output cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PRIOR = 8'b0000_0010,
        S_DENOM = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_MULG  = 8'b0001_0000,
        S_MULC  = 8'b0010_0000,
        S_POST  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // output register can take a new beat
    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_PRIOR;
            S_PRIOR: state_next = S_DENOM;
            S_DENOM: state_next = S_DIV;
            S_DIV:   if (div_done) state_next = S_MULG;
            S_MULG:  state_next = S_MULC;
            S_MULC:  state_next = S_POST;
            S_POST:  state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        cmd            = '0;
        cmd.load_in    = (state_reg == S_IDLE) && in_valid;
        cmd.calc_prior = (state_reg == S_PRIOR);
        cmd.div_init   = (state_reg == S_DENOM);
        cmd.div_step   = (state_reg == S_DIV);
        cmd.mul_gain   = (state_reg == S_MULG);
        cmd.mul_cov    = (state_reg == S_MULC);
        cmd.update_cov = (state_reg == S_POST);
        cmd.load_out   = (state_reg == S_OUT) && out_free;
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/skf_datapath.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter datapath
// Noise registers, filter state, restoring gain divider and one shared
// signed multiplier used for the estimate and covariance updates.
// ----------------------------------------------------------------------------
module skf_datapath
    import skf_pkg::*;
#(
    parameter int FRAC_BITS    = 12,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [REG_W-1:0]               cfg_data,
    input  cmd_t                           cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] measurement,
    output logic signed [SAMPLE_WIDTH-1:0] estimate,
    output logic                           div_done
);

    localparam int COV_W = SAMPLE_WIDTH + 2;
    localparam int DEN_W = ((COV_W > REG_W) ? COV_W : REG_W) + 1;
    localparam int REM_W = DEN_W + 1;
    localparam int INN_W = SAMPLE_WIDTH + 1;
    localparam int SUM_W = SAMPLE_WIDTH + 2;
    localparam int A_W   = COV_W + 1;
    localparam int B_W   = GAIN_W + 1;
    localparam int P_W   = A_W + B_W;

    localparam logic [REG_W-1:0] Q_RESET = REG_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic [REG_W-1:0] R_RESET = REG_W'((64'd555 << FRAC_BITS) / 64'd1000);

    localparam logic signed [SAMPLE_WIDTH-1:0] EST_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] EST_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // configuration and filter state
    logic [REG_W-1:0]               q_reg;
    logic [REG_W-1:0]               r_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg, x_next;
    logic [COV_W-1:0]               p_reg;

    // per-sample working registers
    logic signed [SAMPLE_WIDTH-1:0] z_reg;
    logic [COV_W-1:0]               prior_reg, prior_next;
    logic signed [INN_W-1:0]        innov_reg;
    logic [DEN_W-1:0]               denom_reg;
    logic [DEN_W-1:0]               rem_reg, rem_next;
    logic [GAIN_BITS-1:0]           quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]           cnt_reg;
    logic                           denom_zero_reg;
    logic                           r_zero_reg;
    logic [GAIN_W-1:0]              gain_reg, gain_next;
    logic signed [P_W-1:0]          mul_reg;
    logic signed [SAMPLE_WIDTH-1:0] est_reg;

    logic [DEN_W-1:0]               prior_sum;
    logic [DEN_W-1:0]               denom_next;
    logic [REM_W-1:0]               rem_shift;
    logic                           sub_ok;
    logic signed [A_W-1:0]          mul_a;
    logic signed [B_W-1:0]          mul_b;
    logic [GAIN_W-1:0]              one_minus_gain;
    logic signed [SUM_W-1:0]        x_ext;
    logic signed [SUM_W-1:0]        corr;
    logic signed [SUM_W-1:0]        x_sum;

    // prior covariance, saturated to the covariance range
    assign prior_sum = DEN_W'(p_reg) + DEN_W'(q_reg);
    always_comb
    begin
        if (prior_sum[DEN_W-1:COV_W] != '0)
            prior_next = '1;
        else
            prior_next = prior_sum[COV_W-1:0];
    end

    assign denom_next = DEN_W'(prior_reg) + DEN_W'(r_reg);

    // one restoring division step, remainder never above the divisor
    assign rem_shift = {rem_reg, 1'b0};
    assign sub_ok    = (rem_shift >= REM_W'(denom_reg));
    always_comb
    begin
        if (sub_ok)
            rem_next = DEN_W'(rem_shift - REM_W'(denom_reg));
        else
            rem_next = rem_shift[DEN_W-1:0];
        quo_next = {quo_reg[GAIN_BITS-2:0], sub_ok};
    end

    assign div_done = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    // gain, with the zero-denominator and zero-noise special cases
    always_comb
    begin
        if (denom_zero_reg)
            gain_next = '0;
        else if (r_zero_reg)
            gain_next = GAIN_ONE;
        else
            gain_next = {1'b0, quo_next};
    end

    // shared multiplier operands
    assign one_minus_gain = GAIN_ONE - gain_reg;
    always_comb
    begin
        if (cmd.mul_cov)
        begin
            mul_a = $signed(A_W'(prior_reg));
            mul_b = $signed(B_W'(one_minus_gain));
        end
        else
        begin
            mul_a = A_W'(innov_reg);
            mul_b = $signed(B_W'(gain_reg));
        end
    end

    // estimate update: floor of the scaled correction, then saturate
    assign x_ext = SUM_W'(x_reg);
    assign corr  = mul_reg[GAIN_BITS +: SUM_W];
    assign x_sum = x_ext + corr;
    always_comb
    begin
        if (x_sum[SUM_W-1:SAMPLE_WIDTH-1] == '0 || x_sum[SUM_W-1:SAMPLE_WIDTH-1] == '1)
            x_next = x_sum[SAMPLE_WIDTH-1:0];
        else if (x_sum[SUM_W-1])
            x_next = EST_MIN;
        else
            x_next = EST_MAX;
    end

    // noise registers and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= Q_RESET;
            r_reg <= R_RESET;
            x_reg <= '0;
            p_reg <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == REG_PROCESS_NOISE)
                q_reg <= cfg_data;
            if (cfg_write && cfg_index == REG_MEASUREMENT_NOISE)
                r_reg <= cfg_data;
            if (cmd.mul_cov)
                x_reg <= x_next;
            if (cmd.update_cov)
                p_reg <= mul_reg[GAIN_BITS +: COV_W];
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            z_reg <= measurement;
        if (cmd.calc_prior)
        begin
            prior_reg <= prior_next;
            innov_reg <= INN_W'(z_reg) - INN_W'(x_reg);
        end
        if (cmd.div_init)
        begin
            denom_reg      <= denom_next;
            rem_reg        <= DEN_W'(prior_reg);
            quo_reg        <= '0;
            cnt_reg        <= '0;
            denom_zero_reg <= (denom_next == '0);
            r_zero_reg     <= (r_reg == '0);
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg + 1'b1;
            if (div_done)
                gain_reg <= gain_next;
        end
        if (cmd.mul_gain || cmd.mul_cov)
            mul_reg <= mul_a * mul_b;
        if (cmd.load_out)
            est_reg <= x_reg;
    end

    assign estimate = est_reg;

endmodule

// ===== rtl/core/scalar_kalman_filter_unit.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter unit
// One predict/correct pass of a one-dimensional Kalman filter per sample.
//
//   channel  direction  signals                         payload
//   in       sink       in_valid, in_ready              measurement
//   out      source     out_valid, out_ready            estimate
//   cfg      sink       cfg_write, cfg_index, cfg_data  noise registers
//
// A sample passes through the prior, the 16-step restoring gain divider, and
// the multiply and hand-off steps before the next sample is accepted.
// The estimate beat is registered in the hand-off step.
// Reset clears estimate and covariance and loads the default noise values.
// A stalled output holds its beat; the next sample is still taken, and its
// result waits in the last step until the output register is free.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_unit
    import skf_pkg::*;
#(
    parameter int FRAC_BITS    = 12,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [REG_W-1:0]               cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] measurement,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] estimate
);

    cmd_t cmd;
    logic div_done;

    // sequencer
    skf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .div_done  (div_done),
        .cmd       (cmd)
    );

    // arithmetic and state
    skf_datapath #(
        .FRAC_BITS    (FRAC_BITS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .measurement (measurement),
        .estimate    (estimate),
        .div_done    (div_done)
    );

    // an accepted sample keeps the input closed on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input reopened straight after a sample was taken");

    // a result beat never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("pending estimate overwritten");

    // loading the result raises valid on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("estimate loaded without valid");

    // datapath commands never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("overlapping datapath commands");

endmodule

// ===== tb/tb_scalar_kalman_filter_unit.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter unit testbench
// Drives measurement beats through the valid/ready input and checks every
// estimate beat against a cycle-free model of the predict/correct update,
// kept in step with the noise registers written between phases. A short
// table of corner cases runs first, then random phases with random noise
// settings, random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
module tb_scalar_kalman_filter_unit;
    import skf_pkg::*;

    localparam int FRAC_BITS    = 12;
    localparam int SW           = 16;
    localparam int COV_W        = SW + 2;
    localparam longint COV_MAX  = (64'sd1 <<< COV_W) - 1;
    localparam longint GAIN_UNITY = 64'sd1 <<< GAIN_BITS;
    localparam longint EST_MAX  = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint EST_MIN  = -EST_MAX - 1;

    // index codes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int N_ITEMS      = 1650;
    localparam int IDLE_SETTLE  = 4;
    localparam int END_SETTLE   = 30;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 2000;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0]         cfg_index = '0;
    logic [REG_W-1:0]               cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic signed [SW-1:0]           measurement = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [SW-1:0]           estimate;

    // filter state and noise registers as the block should hold them
    logic signed [SW-1:0]           est_x;
    logic [COV_W-1:0]               cov_p;
    logic [REG_W-1:0]               noise_q;
    logic [REG_W-1:0]               noise_r;

    logic signed [SW-1:0]           pending_estimates [$];

    int fail_count     = 0;
    int samples_sent   = 0;
    int estimates_seen = 0;
    int writes_done    = 0;
    int settings_used  = 0;
    int send_calm      = 0;
    int recv_calm      = 0;
    int stall_cycles   = 0;

    // corner-case table
    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [REG_W-1:0]       data;
        logic                   hand_checked;
        logic [SW-1:0]          want;
    } directed_row_t;

    localparam int N_DIRECTED = 24;

    directed_row_t directed_rows [N_DIRECTED] = '{
        // first sample after reset leaves the estimate at zero
        '{ROW_SAMPLE, '0, 16'h0000, 1'b1, 16'h0000},
        '{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 16'h8000, 1'b0, 16'h0000},
        // zero noise: gain of one takes the sample, then zero denominator holds it
        '{ROW_WRITE, REG_PROCESS_NOISE, 16'h0000, 1'b0, 16'h0000},
        '{ROW_WRITE, REG_MEASUREMENT_NOISE, 16'h0000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 16'h3039, 1'b1, 16'h3039},
        '{ROW_SAMPLE, '0, 16'hFE0C, 1'b1, 16'h3039},
        '{ROW_SAMPLE, '0, 16'h8000, 1'b1, 16'h3039},
        // largest process noise, smallest measurement noise, corrections both ways
        '{ROW_WRITE, REG_PROCESS_NOISE, 16'hFFFF, 1'b0, 16'h0000},
        '{ROW_WRITE, REG_MEASUREMENT_NOISE, 16'h0001, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 16'h8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 16'hFFFF, 1'b0, 16'h0000},
        // writes to unmapped indexes must change nothing
        '{ROW_WRITE, REG_SPARE_2, 16'hFFFF, 1'b0, 16'h0000},
        '{ROW_WRITE, REG_SPARE_3, 16'h5A5A, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 16'h0000, 1'b0, 16'h0000},
        // no process noise, largest measurement noise
        '{ROW_WRITE, REG_PROCESS_NOISE, 16'h0000, 1'b0, 16'h0000},
        '{ROW_WRITE, REG_MEASUREMENT_NOISE, 16'hFFFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 16'h03E8, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 16'hFC18, 1'b0, 16'h0000},
        // back to the reset values
        '{ROW_WRITE, REG_PROCESS_NOISE, 16'h0800, 1'b0, 16'h0000},
        '{ROW_WRITE, REG_MEASUREMENT_NOISE, 16'h08E1, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 16'h5555, 1'b0, 16'h0000},
        '{ROW_SAMPLE, '0, 16'hAAAA, 1'b0, 16'h0000}
    };

    scalar_kalman_filter_unit #(
        .FRAC_BITS    (FRAC_BITS),
        .SAMPLE_WIDTH (SW)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .estimate    (estimate)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // one predict/correct update, returns the new estimate
    function automatic logic signed [SW-1:0] kalman_update(input logic signed [SW-1:0] z);
        longint prior;
        longint denom;
        longint gain;
        longint next_x;
        longint post;
        prior = longint'(cov_p) + longint'(noise_q);
        if (prior > COV_MAX)
            prior = COV_MAX;
        denom = prior + longint'(noise_r);
        gain = (denom == 0) ? 64'sd0 : (prior <<< GAIN_BITS) / denom;
        if (gain > GAIN_UNITY)
            gain = GAIN_UNITY;
        // arithmetic shift of the signed product floors towards minus infinity
        next_x = longint'(est_x) + (((longint'(z) - longint'(est_x)) * gain) >>> GAIN_BITS);
        if (next_x > EST_MAX)
            next_x = EST_MAX;
        if (next_x < EST_MIN)
            next_x = EST_MIN;
        post = ((GAIN_UNITY - gain) * prior) >>> GAIN_BITS;
        if (post > COV_MAX)
            post = COV_MAX;
        est_x = next_x[SW-1:0];
        cov_p = post[COV_W-1:0];
        return est_x;
    endfunction

    // idle cycles before the next beat, with occasional stretches of none
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // half full-range samples, some extremes, the rest close to the estimate
    function automatic logic signed [SW-1:0] pick_measurement();
        int sel;
        longint near;
        sel = $urandom_range(0, 19);
        if (sel < 10)
            return SW'($urandom_range(0, 65535));
        if (sel < 12)
            return 16'sh7FFF;
        if (sel < 14)
            return 16'sh8000;
        near = longint'(est_x) + longint'($urandom_range(0, 512)) - 256;
        if (near > EST_MAX)
            near = EST_MAX;
        if (near < EST_MIN)
            near = EST_MIN;
        return near[SW-1:0];
    endfunction

    task automatic send_sample(input logic signed [SW-1:0] z, input logic hand_checked,
                               input logic signed [SW-1:0] want);
        int gap;
        logic signed [SW-1:0] predicted;
        gap = draw_gap(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        measurement <= z;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        predicted = kalman_update(z);
        pending_estimates.push_back(hand_checked ? want : predicted);
        samples_sent++;
    endtask

    // stop offering samples and let every estimate come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [REG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == REG_PROCESS_NOISE)
            noise_q = val;
        else if (idx == REG_MEASUREMENT_NOISE)
            noise_r = val;
        writes_done++;
    endtask

    // stimulus
    initial
    begin : stimulus
        logic [REG_W-1:0] q_val;
        logic [REG_W-1:0] r_val;
        int burst;
        est_x   = '0;
        cov_p   = '0;
        noise_q = REG_W'(1 << (FRAC_BITS - 1));
        noise_r = REG_W'((555 << FRAC_BITS) / 1000);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner cases
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(directed_rows[i].index, directed_rows[i].data);
            end
            else
            begin
                send_sample(directed_rows[i].data, directed_rows[i].hand_checked,
                            directed_rows[i].want);
            end
        end

        // random phases, each under its own noise setting
        while (samples_sent < N_ITEMS)
        begin
            wait_idle();
            case ($urandom_range(0, 5))
                0:       q_val = '0;
                1:       q_val = '1;
                2, 3:    q_val = REG_W'($urandom_range(0, 255));
                default: q_val = REG_W'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 9))
                0:       r_val = '0;
                1:       r_val = REG_W'(1);
                2:       r_val = '1;
                default: r_val = REG_W'($urandom_range(1, 65535));
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(REG_PROCESS_NOISE, q_val);
                write_reg(REG_MEASUREMENT_NOISE, r_val);
            end
            else
            begin
                write_reg(REG_MEASUREMENT_NOISE, r_val);
                write_reg(REG_PROCESS_NOISE, q_val);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          REG_W'($urandom_range(0, 65535)));
            settings_used++;
            burst = $urandom_range(40, 160);
            for (int k = 0; k < burst && samples_sent < N_ITEMS; k++)
                send_sample(pick_measurement(), 1'b0, '0);
        end

        // drain and report
        wait_idle();
        repeat (END_SETTLE) @(posedge clk);
        $display("covered %0d samples and %0d estimate beats", samples_sent, estimates_seen);
        $display("across %0d register writes and %0d random noise settings",
                 writes_done, settings_used);
        if (fail_count == 0)
            $display("scalar_kalman_filter_unit verification clean");
        else
            $display("scalar_kalman_filter_unit verification failed");
        $finish;
    end

    // estimate sink with random stalls and an occasional long hold-off
    initial
    begin : estimate_sink
        int gap;
        logic signed [SW-1:0] want;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (estimates_seen % 600 == 300)
                gap = LONG_HOLD;
            else
                gap = draw_gap(recv_calm);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            if (pending_estimates.size() == 0)
            begin
                fail_count++;
                $display("%0t: estimate beat, expected none, got %0d", $time, estimate);
            end
            else
            begin
                want = pending_estimates.pop_front();
                if (estimate !== want)
                begin
                    fail_count++;
                    $display("%0t: estimate mismatch, expected %0d, got %0d",
                             $time, want, estimate);
                end
            end
            estimates_seen++;
        end
    end

    // watchdog on cycles with no beat and no register write
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d estimates outstanding",
                         $time, STALL_LIMIT, pending_estimates.size());
                $display("scalar_kalman_filter_unit verification failed");
                $finish;
            end
        end
    end

endmodule
